/* design/edf_queue_with_late_drop_macros.svh */
// Assertion helpers for the EDF queue block.
`ifndef EDF_QUEUE_WITH_LATE_DROP_MACROS_SVH
`define EDF_QUEUE_WITH_LATE_DROP_MACROS_SVH

// Same-cycle implication.
`define EDFQ_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication.
`define EDFQ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

/* design/edfq_pkg.sv */
//------------------------------------------------------------------------------
// edfq_pkg
// Shared types and defaults for the EDF queue with late drop.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edfq_pkg;

    localparam int DEF_TASK_SLOTS  = 16;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_LATE_SLOTS  = 3;
    localparam int DEF_TIME_BITS   = 32;
    localparam int OP_W            = 3;
    localparam int KIND_W          = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_ENABLE    = 3'd1,
        OP_DISPATCH  = 3'd2,
        OP_PAUSE     = 3'd3,
        OP_SET_READY = 3'd4,
        OP_REDUCE    = 3'd5
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        K_ACK      = 3'd0,
        K_CANCEL   = 3'd1,
        K_DISPATCH = 3'd2,
        K_NONE     = 3'd3,
        K_READY_OK = 3'd4,
        K_REFUSED  = 3'd5,
        K_FULL     = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ID_ZERO     = 2'd0,
        ID_LATE_OLD = 2'd1,
        ID_HEAD     = 2'd2,
        ID_LATE_NEW = 2'd3
    } t_id_sel;

    typedef struct packed {
        logic    accept;
        logic    wr_create;
        logic    wr_reduce;
        logic    rd_queue;
        logic    key_from_in;
        logic    key_from_mem;
        logic    idx_clr;
        logic    idx_inc;
        logic    idx_dec;
        logic    q_insert;
        logic    q_pop;
        logic    late_push;
        logic    late_pop;
        logic    wait_set;
        logic    wait_clr;
        logic    fin_load;
        logic    out_load;
        logic    out_last;
        logic    out_use_fin;
        t_kind   out_kind;
        t_id_sel out_id;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            waiting;
        logic            full;
        logic            idx_lt_cnt;
        logic            idx_zero;
        logic            start_le_now;
        logic            dl_le_key;
        logic            late_full;
        logic            late_any;
        logic            cnt_any;
        logic            out_free;
    } t_sts;

endpackage

`default_nettype wire

/* design/edfq_dp.sv */
//------------------------------------------------------------------------------
// edfq_dp
// Datapath: task tables, ordered ready queue, late list, waiting flags and
// the result register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edfq_dp #(
    parameter int TASK_SLOTS  = edfq_pkg::DEF_TASK_SLOTS,
    parameter int QUEUE_DEPTH = edfq_pkg::DEF_QUEUE_DEPTH,
    parameter int LATE_SLOTS  = edfq_pkg::DEF_LATE_SLOTS,
    parameter int TIME_BITS   = edfq_pkg::DEF_TIME_BITS,
    parameter int TW          = $clog2(TASK_SLOTS),
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire edfq_pkg::t_cmd            i_cmd,
    output      edfq_pkg::t_sts            o_sts,
    input  wire logic [edfq_pkg::OP_W-1:0] i_op,
    input  wire logic [TW-1:0]             i_task_id,
    input  wire logic [TIME_BITS-1:0]      i_deadline,
    input  wire logic [TIME_BITS-1:0]      i_burst,
    input  wire logic [TIME_BITS-1:0]      i_now,
    output      logic                      o_valid,
    input  wire logic                      i_ready,
    output      logic [edfq_pkg::KIND_W-1:0] o_kind,
    output      logic [TW-1:0]             o_task_id_res,
    output      logic [CW-1:0]             o_ready_count,
    output      logic                      o_last
);

    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW  = $clog2(LATE_SLOTS + 1);
    localparam int LIW = (LATE_SLOTS > 1) ? $clog2(LATE_SLOTS) : 1;

    logic [TIME_BITS-1:0] r_dl_mem [TASK_SLOTS];
    logic [TIME_BITS-1:0] r_bu_mem [TASK_SLOTS];
    logic [TIME_BITS-1:0] r_rd_dl, r_rd_bu;
    logic [TW-1:0]        r_q [QUEUE_DEPTH];
    logic [TW-1:0]        n_q [QUEUE_DEPTH];
    logic [TW-1:0]        r_late [LATE_SLOTS];
    logic [TW-1:0]        n_late [LATE_SLOTS];
    logic [TASK_SLOTS-1:0] r_wait;
    logic [CW-1:0]        r_cnt, r_idx, r_fin;
    logic [LW-1:0]        r_late_cnt;
    logic [edfq_pkg::OP_W-1:0] r_op;
    logic [TW-1:0]        r_slot;
    logic [TIME_BITS-1:0] r_dl, r_bu, r_now, r_key;
    logic [TW-1:0]        rd_addr, head, late_new, id_sel;
    logic [TIME_BITS-1:0] start;

    assign head     = r_q[0];
    assign late_new = r_late[LIW'(r_late_cnt - LW'(1))];
    assign rd_addr  = i_cmd.rd_queue ? r_q[r_idx[QW-1:0]] : r_slot;
    assign start    = r_rd_dl - r_rd_bu;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_slot <= i_task_id;
            r_dl   <= i_deadline;
            r_bu   <= i_burst;
            r_now  <= i_now;
        end
        r_rd_dl <= r_dl_mem[rd_addr];
        r_rd_bu <= r_bu_mem[rd_addr];
        if (i_cmd.wr_create) begin
            r_dl_mem[r_slot] <= r_dl;
        end
        if (i_cmd.wr_create || i_cmd.wr_reduce) begin
            r_bu_mem[r_slot] <= i_cmd.wr_create ? r_bu : (r_rd_bu - r_bu);
        end
        if (i_cmd.key_from_in) begin
            r_key <= r_dl;
        end else if (i_cmd.key_from_mem) begin
            r_key <= r_rd_dl;
        end
        if (i_cmd.fin_load) begin
            r_fin <= r_cnt - r_idx - CW'(r_cnt != r_idx);
        end
        r_q    <= n_q;
        r_late <= n_late;
    end

    always_comb begin
        n_q = r_q;
        if (i_cmd.q_insert) begin
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (CW'(i) > r_idx) begin
                    n_q[i] = r_q[i-1];
                end
            end
            n_q[r_idx[QW-1:0]] = r_slot;
        end else if (i_cmd.q_pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
    end

    always_comb begin
        n_late = r_late;
        if (i_cmd.late_push) begin
            if (r_late_cnt == LW'(LATE_SLOTS)) begin
                for (int i = 0; i < LATE_SLOTS - 1; i++) begin
                    n_late[i] = r_late[i+1];
                end
                n_late[LATE_SLOTS-1] = head;
            end else begin
                n_late[r_late_cnt[LIW-1:0]] = head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_idx      <= '0;
            r_late_cnt <= '0;
            r_wait     <= '0;
        end else begin
            if (i_cmd.q_insert) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.q_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - CW'(1);
            end
            if (i_cmd.late_push && r_late_cnt != LW'(LATE_SLOTS)) begin
                r_late_cnt <= r_late_cnt + LW'(1);
            end else if (i_cmd.late_pop) begin
                r_late_cnt <= r_late_cnt - LW'(1);
            end
            if (i_cmd.wait_set) begin
                r_wait[r_slot] <= 1'b1;
            end else if (i_cmd.wait_clr) begin
                r_wait[r_slot] <= 1'b0;
            end
        end
    end

    always_comb begin
        unique case (i_cmd.out_id)
            edfq_pkg::ID_LATE_OLD: id_sel = r_late[0];
            edfq_pkg::ID_HEAD:     id_sel = head;
            edfq_pkg::ID_LATE_NEW: id_sel = late_new;
            default:               id_sel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            o_kind        <= i_cmd.out_kind;
            o_task_id_res <= id_sel;
            o_ready_count <= i_cmd.out_use_fin ? r_fin : r_cnt;
            o_last        <= i_cmd.out_last;
        end
    end

    assign o_sts.op           = r_op;
    assign o_sts.waiting      = r_wait[r_slot];
    assign o_sts.full         = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_sts.idx_lt_cnt   = (r_idx < r_cnt);
    assign o_sts.idx_zero     = (r_idx == '0);
    assign o_sts.start_le_now = (start <= r_now);
    assign o_sts.dl_le_key    = (r_rd_dl <= r_key);
    assign o_sts.late_full    = (r_late_cnt == LW'(LATE_SLOTS));
    assign o_sts.late_any     = (r_late_cnt != '0);
    assign o_sts.cnt_any      = (r_cnt != '0);
    assign o_sts.out_free     = !o_valid || i_ready;

endmodule

`default_nettype wire

/* design/edfq_ctrl.sv */
//------------------------------------------------------------------------------
// edfq_ctrl
// Controller: sequences queue scans, inserts, late moves and result output.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edfq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_ready,
    input  wire edfq_pkg::t_sts i_sts,
    output      edfq_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_KEY_RD, S_KEY_LD, S_SCAN_RD, S_SCAN_CMP, S_INS,
        S_RED_RD, S_RED_WR, S_EMIT, S_LATE_RD, S_LATE_CMP, S_DROP, S_FINAL
    } t_state;

    t_state          r_state, n_state;
    edfq_pkg::t_kind r_kind, n_kind;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                n_kind  = edfq_pkg::K_ACK;
                n_state = S_EMIT;
                unique case (i_sts.op)
                    edfq_pkg::OP_CREATE: begin
                        o_cmd.wr_create   = 1'b1;
                        o_cmd.key_from_in = 1'b1;
                        o_cmd.idx_clr     = 1'b1;
                        if (i_sts.full) n_kind = edfq_pkg::K_FULL;
                        else n_state = S_SCAN_RD;
                    end
                    edfq_pkg::OP_ENABLE: begin
                        if (i_sts.full) n_kind = edfq_pkg::K_FULL;
                        else n_state = S_KEY_RD;
                    end
                    edfq_pkg::OP_DISPATCH: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_LATE_RD;
                    end
                    edfq_pkg::OP_PAUSE: o_cmd.wait_set = 1'b1;
                    edfq_pkg::OP_SET_READY: begin
                        if (!i_sts.waiting) begin
                            n_kind = edfq_pkg::K_REFUSED;
                        end else begin
                            o_cmd.wait_clr = 1'b1;
                            if (i_sts.full) begin
                                n_kind = edfq_pkg::K_FULL;
                            end else begin
                                n_kind  = edfq_pkg::K_READY_OK;
                                n_state = S_KEY_RD;
                            end
                        end
                    end
                    edfq_pkg::OP_REDUCE: n_state = S_RED_RD;
                    default: ;
                endcase
            end
            S_KEY_RD: n_state = S_KEY_LD;
            S_KEY_LD: begin
                o_cmd.key_from_mem = 1'b1;
                o_cmd.idx_clr      = 1'b1;
                n_state            = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.rd_queue = 1'b1;
                n_state = i_sts.idx_lt_cnt ? S_SCAN_CMP : S_INS;
            end
            S_SCAN_CMP: begin
                if (i_sts.dl_le_key) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_cmd.q_insert = 1'b1;
                n_state        = S_EMIT;
            end
            S_RED_RD: n_state = S_RED_WR;
            S_RED_WR: begin
                o_cmd.wr_reduce = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.out_kind = r_kind;
                    o_cmd.out_id   = edfq_pkg::ID_ZERO;
                    n_state        = S_IDLE;
                end
            end
            S_LATE_RD: begin
                o_cmd.rd_queue = 1'b1;
                if (i_sts.idx_lt_cnt) begin
                    n_state = S_LATE_CMP;
                end else begin
                    o_cmd.fin_load = 1'b1;
                    n_state        = S_DROP;
                end
            end
            S_LATE_CMP: begin
                if (i_sts.start_le_now) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_LATE_RD;
                end else begin
                    o_cmd.fin_load = 1'b1;
                    n_state        = S_DROP;
                end
            end
            S_DROP: begin
                if (i_sts.idx_zero) begin
                    n_state = S_FINAL;
                end else if (!i_sts.late_full || i_sts.out_free) begin
                    o_cmd.late_push   = 1'b1;
                    o_cmd.q_pop       = 1'b1;
                    o_cmd.idx_dec     = 1'b1;
                    o_cmd.out_load    = i_sts.late_full;
                    o_cmd.out_use_fin = 1'b1;
                    o_cmd.out_kind    = edfq_pkg::K_CANCEL;
                    o_cmd.out_id      = edfq_pkg::ID_LATE_OLD;
                end
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_last    = 1'b1;
                    o_cmd.out_use_fin = 1'b1;
                    n_state           = S_IDLE;
                    priority if (i_sts.cnt_any) begin
                        o_cmd.out_kind = edfq_pkg::K_DISPATCH;
                        o_cmd.out_id   = edfq_pkg::ID_HEAD;
                        o_cmd.q_pop    = 1'b1;
                    end else if (i_sts.late_any) begin
                        o_cmd.out_kind = edfq_pkg::K_DISPATCH;
                        o_cmd.out_id   = edfq_pkg::ID_LATE_NEW;
                        o_cmd.late_pop = 1'b1;
                    end else begin
                        o_cmd.out_kind = edfq_pkg::K_NONE;
                        o_cmd.out_id   = edfq_pkg::ID_ZERO;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= edfq_pkg::K_ACK;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

`default_nettype wire

/* design/edf_queue_with_late_drop.sv */
// Enqueues walk the ready entries to find the insert point, dispatch walks and
// drops the expired heads, and any output stall holds a result until it is taken.
// One transaction at a time; the controller FSM and the registered-read
// task tables set the pace. Results leave through a one-deep output register.
// Synchronous active-low reset empties queue, late list and waiting flags.
//------------------------------------------------------------------------------
// edf_queue_with_late_drop
// Earliest-deadline-first ready queue with a bounded late list.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "edf_queue_with_late_drop_macros.svh"

module edf_queue_with_late_drop #(
    parameter int TASK_SLOTS  = edfq_pkg::DEF_TASK_SLOTS,
    parameter int QUEUE_DEPTH = edfq_pkg::DEF_QUEUE_DEPTH,
    parameter int LATE_SLOTS  = edfq_pkg::DEF_LATE_SLOTS,
    parameter int TIME_BITS   = edfq_pkg::DEF_TIME_BITS,
    parameter int TW          = $clog2(TASK_SLOTS),
    parameter int CW          = $clog2(QUEUE_DEPTH + 1),
    parameter int S_DW        = ((TW + 3 * TIME_BITS + 7) / 8) * 8,
    parameter int M_DW        = ((TW + CW + 7) / 8) * 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output      logic                        s_axis_tready,
    // task_id, deadline, burst, now
    input  wire logic [S_DW-1:0]             s_axis_tdata,
    // opcode
    input  wire logic [edfq_pkg::OP_W-1:0]   s_axis_tuser,
    output      logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // task_id_res, ready_count
    output      logic [M_DW-1:0]             m_axis_tdata,
    // kind
    output      logic [edfq_pkg::KIND_W-1:0] m_axis_tuser,
    output      logic                        m_axis_tlast
);

    edfq_pkg::t_cmd cmd;
    edfq_pkg::t_sts sts;
    logic [TW-1:0]  task_id_res;
    logic [CW-1:0]  ready_count;

    edfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    edfq_dp #(
        .TASK_SLOTS  (TASK_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LATE_SLOTS  (LATE_SLOTS),
        .TIME_BITS   (TIME_BITS),
        .TW          (TW),
        .CW          (CW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (s_axis_tuser),
        .i_task_id     (s_axis_tdata[TW-1:0]),
        .i_deadline    (s_axis_tdata[TW +: TIME_BITS]),
        .i_burst       (s_axis_tdata[TW + TIME_BITS +: TIME_BITS]),
        .i_now         (s_axis_tdata[TW + 2 * TIME_BITS +: TIME_BITS]),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_kind        (m_axis_tuser),
        .o_task_id_res (task_id_res),
        .o_ready_count (ready_count),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = M_DW'({ready_count, task_id_res});

    `EDFQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `EDFQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, m_axis_tvalid, ready_count <= CW'(QUEUE_DEPTH))
    `EDFQ_ASSERT_IMPL(a_cancel_not_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == edfq_pkg::K_CANCEL, !m_axis_tlast)

endmodule

`default_nettype wire
